// ----- rtl/core/tono_pkg.sv -----
package tono_pkg;

    // Telnet command and option codes.
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_GA   = 8'd249;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;
    localparam logic [7:0] TTYPE_SEND = 8'd1;
    localparam logic [7:0] TTYPE_IS   = 8'd0;

    // Negotiation verbs as offsets from WILL.
    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    // Echo mode codes.
    localparam logic [1:0] ECHO_UNKNOWN = 2'd0;
    localparam logic [1:0] ECHO_SERVER  = 2'd1;
    localparam logic [1:0] ECHO_STOPPED = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_TX   = 2'd1;
    localparam logic [1:0] KIND_GA   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COLS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LINES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_LINE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_NAME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEN     = 3'd4;
    localparam int CFG_DATA_W = 64;

    localparam logic [15:0] COLS_RESET  = 16'd80;
    localparam logic [15:0] LINES_RESET = 16'd24;

    // Defaults for the top-level parameters.
    localparam int TERM_MAX_CHARS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Work handed from the parser to the reply sequencer.
    typedef enum logic [2:0] {
        JOB_DATA,
        JOB_GA,
        JOB_NEG,
        JOB_NAWS,
        JOB_TTYPE
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  value;
        logic [7:0]  opt;
        logic [1:0]  echo;
        logic        naws;
    } t_job;

endpackage

// ----- rtl/core/tono_in_if.sv -----
interface tono_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

// ----- rtl/core/tono_out_if.sv -----
interface tono_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic [1:0] echo_mode;
    logic       naws_on;

    modport source (output valid, output kind, output value, output last,
                    output echo_mode, output naws_on, input ready);
    modport sink (input valid, input kind, input value, input last,
                  input echo_mode, input naws_on, output ready);
endinterface

// ----- rtl/core/telnet_option_negotiator_unit.sv -----
// Channel   Dir  Payload                                  Transaction when
// i_in      in   op, rx_byte                              valid && ready
// o_out     out  kind, value, last, echo_mode, naws_on    valid && ready
// i_cfg_*   in   i_cfg_idx, i_cfg_data                    i_cfg_we
//
// The parser takes one transaction per cycle while its job queue has room.
// Each result is one output transaction of the reply sequencer, so a data byte
// gives one result and a negotiation reply up to 16 results (3 plus up to 13 for
// the window size message); TERMINAL-TYPE replies give 6 plus the name length.
// Reset is synchronous and clears the parser, the queue and the output.
// A stalled output fills the queue, after which i_in.ready drops.
module telnet_option_negotiator_unit #(
    parameter int TERM_MAX_CHARS = tono_pkg::TERM_MAX_CHARS_DEF,
    parameter int QUEUE_DEPTH    = tono_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tono_in_if.sink                         i_in,
    tono_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [tono_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tono_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tono_pkg::t_job push_job, head_job;
    logic           push, pop, q_full, q_empty;

    // Parser and classifier.
    tono_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Job queue between parser and reply sequencer.
    tono_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Reply sequencer with configuration and output register.
    tono_back #(
        .TERM_MAX_CHARS (TERM_MAX_CHARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_job      (head_job),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ----- rtl/core/tono_front.sv -----
module tono_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tono_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output tono_pkg::t_job o_job
);

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_IAC,
        PH_OPT,
        PH_SB,
        PH_SBIAC
    } t_phase;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] opt;
        logic [7:0] sec;
    } t_sub;

    t_phase     r_phase, n_phase;
    logic [1:0] r_verb, n_verb;
    t_sub       r_sub, n_sub;
    logic       r_naws, n_naws;
    logic [1:0] r_echo, n_echo;
    logic       accept;
    logic [7:0] b;

    // Keep the first two subnegotiation payload bytes.
    function automatic t_sub sub_record(input t_sub s, input logic [7:0] d);
        t_sub r;
        r = s;
        if (s.cnt == 2'd0) begin
            r.opt = d;
        end else if (s.cnt == 2'd1) begin
            r.sec = d;
        end
        if (s.cnt < 2'd2) begin
            r.cnt = s.cnt + 2'd1;
        end
        return r;
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.rx_byte;

    // Parse one transaction and classify the work it causes.
    always_comb begin
        n_phase    = r_phase;
        n_verb     = r_verb;
        n_sub      = r_sub;
        n_naws     = r_naws;
        n_echo     = r_echo;
        o_push     = 1'b0;
        o_job.kind  = tono_pkg::JOB_DATA;
        o_job.value = b;
        o_job.opt   = b;
        if (accept) begin
            if (i_in.op) begin
                o_job.kind = tono_pkg::JOB_NAWS;
                o_push     = r_naws;
            end else begin
                case (r_phase)
                    PH_NORMAL: begin
                        if (b == tono_pkg::B_IAC) begin
                            n_phase = PH_IAC;
                        end else begin
                            o_push = 1'b1;
                        end
                    end
                    PH_IAC: begin
                        n_phase = PH_NORMAL;
                        if (b >= tono_pkg::B_WILL && b <= tono_pkg::B_DONT) begin
                            n_verb  = 2'(b - tono_pkg::B_WILL);
                            n_phase = PH_OPT;
                        end else if (b == tono_pkg::B_SB) begin
                            n_sub   = '0;
                            n_phase = PH_SB;
                        end else if (b == tono_pkg::B_GA) begin
                            o_job.kind  = tono_pkg::JOB_GA;
                            o_job.value = 8'd0;
                            o_push      = 1'b1;
                        end else if (b == tono_pkg::B_IAC) begin
                            o_push = 1'b1;
                        end
                    end
                    PH_OPT: begin
                        n_phase    = PH_NORMAL;
                        o_job.kind = tono_pkg::JOB_NEG;
                        o_push     = 1'b1;
                        if (r_verb == tono_pkg::VERB_WILL || r_verb == tono_pkg::VERB_WONT) begin
                            o_job.value = tono_pkg::B_DONT;
                        end else if (r_verb == tono_pkg::VERB_DONT) begin
                            o_job.value = tono_pkg::B_WONT;
                        end else if (b == tono_pkg::OPT_ECHO || b == tono_pkg::OPT_TTYPE
                                     || b == tono_pkg::OPT_NAWS) begin
                            o_job.value = tono_pkg::B_WILL;
                        end else begin
                            o_job.value = tono_pkg::B_WONT;
                        end
                        if (b == tono_pkg::OPT_ECHO) begin
                            if (r_verb == tono_pkg::VERB_WILL) begin
                                n_echo = tono_pkg::ECHO_SERVER;
                            end else if (r_verb == tono_pkg::VERB_WONT) begin
                                n_echo = tono_pkg::ECHO_STOPPED;
                            end
                        end else if (b == tono_pkg::OPT_NAWS) begin
                            if (r_verb == tono_pkg::VERB_WILL) begin
                                o_job.value = tono_pkg::B_DO;
                            end
                            n_naws = (r_verb == tono_pkg::VERB_WILL)
                                  || (r_verb == tono_pkg::VERB_DO);
                        end
                    end
                    PH_SB: begin
                        if (b == tono_pkg::B_IAC) begin
                            n_phase = PH_SBIAC;
                        end else begin
                            n_sub = sub_record(r_sub, b);
                        end
                    end
                    PH_SBIAC: begin
                        if (b == tono_pkg::B_SE) begin
                            n_phase    = PH_NORMAL;
                            o_job.kind = tono_pkg::JOB_TTYPE;
                            o_push     = (r_sub.cnt == 2'd2)
                                      && (r_sub.opt == tono_pkg::OPT_TTYPE)
                                      && (r_sub.sec == tono_pkg::TTYPE_SEND);
                        end else begin
                            n_phase = PH_SB;
                            n_sub   = sub_record(r_sub, tono_pkg::B_IAC);
                            if (b != tono_pkg::B_IAC) begin
                                n_sub = sub_record(n_sub, b);
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_NORMAL;
                    end
                endcase
            end
        end
        o_job.echo = n_echo;
        o_job.naws = n_naws;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_verb  <= '0;
            r_sub   <= '0;
            r_naws  <= 1'b0;
            r_echo  <= tono_pkg::ECHO_UNKNOWN;
        end else begin
            r_phase <= n_phase;
            r_verb  <= n_verb;
            r_sub   <= n_sub;
            r_naws  <= n_naws;
            r_echo  <= n_echo;
        end
    end

endmodule

// ----- rtl/core/tono_fifo.sv -----
module tono_fifo #(
    parameter int DEPTH = tono_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tono_pkg::t_job i_job,
    input  logic           i_pop,
    output tono_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tono_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/tono_back.sv -----
module tono_back #(
    parameter int TERM_MAX_CHARS = tono_pkg::TERM_MAX_CHARS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tono_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tono_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  tono_pkg::t_job                  i_job,
    input  logic                            i_empty,
    output logic                            o_pop,
    tono_out_if.source                      o_out
);

    localparam int NW  = 8 * TERM_MAX_CHARS;
    localparam int NIW = (TERM_MAX_CHARS > 1) ? $clog2(TERM_MAX_CHARS) : 1;

    // Step numbers of a negotiation reply followed by a window size message.
    localparam logic [3:0] ST_NEG_OPT   = 4'd2;
    localparam logic [3:0] ST_NAWS_BASE = 4'd3;
    localparam logic [3:0] ST_NAWS_SB   = 4'd4;
    localparam logic [3:0] ST_NAWS_OPT  = 4'd5;
    localparam logic [3:0] ST_COLS_HI   = 4'd6;
    localparam logic [3:0] ST_COLS_LO   = 4'd7;
    localparam logic [3:0] ST_ROWS_HI   = 4'd8;
    localparam logic [3:0] ST_ROWS_LO   = 4'd9;
    localparam logic [3:0] ST_NAWS_IAC  = 4'd10;
    localparam logic [3:0] ST_NAWS_SE   = 4'd11;
    localparam logic [3:0] ST_TT_HDR    = 4'd4;

    logic [15:0]   r_cols, r_lines;
    logic          r_status;
    logic [NW-1:0] r_term_name;
    logic [3:0]    r_term_len;

    logic [3:0]    r_step;
    logic          r_dup;
    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_value;
    logic          r_last;
    logic [1:0]    r_echo;
    logic          r_naws;

    logic [15:0]   sub_rows, rows;
    logic [3:0]    n_chars;
    logic [3:0]    s, s_name;
    logic [4:0]    name_end;
    logic [NW-1:0] name_word;
    logic          follow;
    logic          load_en, take;
    logic [1:0]    c_kind;
    logic [7:0]    c_value;
    logic          c_last, c_hold;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= tono_pkg::COLS_RESET;
            r_lines     <= tono_pkg::LINES_RESET;
            r_status    <= 1'b0;
            r_term_name <= '0;
            r_term_len  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tono_pkg::CFG_WINDOW_COLS:  r_cols      <= i_cfg_data[15:0];
                tono_pkg::CFG_WINDOW_LINES: r_lines     <= i_cfg_data[15:0];
                tono_pkg::CFG_STATUS_LINE:  r_status    <= i_cfg_data[0];
                tono_pkg::CFG_TERM_NAME:    r_term_name <= i_cfg_data[NW-1:0];
                tono_pkg::CFG_TERM_LEN:     r_term_len  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Reported rows lose one line, two with a status line, and stop at zero.
    assign sub_rows = 16'd1 + 16'(r_status);
    assign rows     = (r_lines >= sub_rows) ? r_lines - sub_rows : 16'd0;

    // Terminal name length clamped to the stored characters.
    assign n_chars   = (r_term_len > 4'(TERM_MAX_CHARS)) ? 4'(TERM_MAX_CHARS) : r_term_len;
    assign name_end  = 5'(ST_TT_HDR) + 5'(n_chars);
    assign s_name    = r_step - ST_TT_HDR;
    assign name_word = r_term_name >> {s_name[NIW-1:0], 3'b000};

    assign s      = (i_job.kind == tono_pkg::JOB_NAWS) ? r_step + ST_NAWS_BASE : r_step;
    assign follow = (i_job.opt == tono_pkg::OPT_NAWS) && i_job.naws;

    // Current result byte of the job at the head of the queue.
    always_comb begin
        c_kind  = tono_pkg::KIND_TX;
        c_value = tono_pkg::B_IAC;
        c_last  = 1'b0;
        c_hold  = 1'b0;
        case (i_job.kind)
            tono_pkg::JOB_DATA: begin
                c_kind  = tono_pkg::KIND_DATA;
                c_value = i_job.value;
                c_last  = 1'b1;
            end
            tono_pkg::JOB_GA: begin
                c_kind  = tono_pkg::KIND_GA;
                c_value = 8'd0;
                c_last  = 1'b1;
            end
            tono_pkg::JOB_NEG, tono_pkg::JOB_NAWS: begin
                case (s)
                    4'd0:        c_value = tono_pkg::B_IAC;
                    4'd1:        c_value = i_job.value;
                    ST_NEG_OPT: begin
                        c_value = i_job.opt;
                        c_last  = !follow;
                    end
                    ST_NAWS_BASE: c_value = tono_pkg::B_IAC;
                    ST_NAWS_SB:   c_value = tono_pkg::B_SB;
                    ST_NAWS_OPT:  c_value = tono_pkg::OPT_NAWS;
                    ST_COLS_HI:   c_value = r_cols[15:8];
                    ST_COLS_LO:   c_value = r_cols[7:0];
                    ST_ROWS_HI:   c_value = rows[15:8];
                    ST_ROWS_LO:   c_value = rows[7:0];
                    ST_NAWS_IAC:  c_value = tono_pkg::B_IAC;
                    ST_NAWS_SE: begin
                        c_value = tono_pkg::B_SE;
                        c_last  = 1'b1;
                    end
                    default: begin
                        c_value = tono_pkg::B_SE;
                        c_last  = 1'b1;
                    end
                endcase
                // A 255 size byte goes out twice.
                c_hold = (s >= ST_COLS_HI) && (s <= ST_ROWS_LO)
                      && (c_value == tono_pkg::B_IAC) && !r_dup;
            end
            tono_pkg::JOB_TTYPE: begin
                if (r_step == 4'd0) begin
                    c_value = tono_pkg::B_IAC;
                end else if (r_step == 4'd1) begin
                    c_value = tono_pkg::B_SB;
                end else if (r_step == 4'd2) begin
                    c_value = tono_pkg::OPT_TTYPE;
                end else if (r_step == 4'd3) begin
                    c_value = tono_pkg::TTYPE_IS;
                end else if (5'(r_step) < name_end) begin
                    c_value = name_word[7:0];
                end else if (5'(r_step) == name_end) begin
                    c_value = tono_pkg::B_IAC;
                end else begin
                    c_value = tono_pkg::B_SE;
                    c_last  = 1'b1;
                end
            end
            default: begin
                c_last = 1'b1;
            end
        endcase
    end

    assign load_en = !r_out_valid || o_out.ready;
    assign take    = load_en && !i_empty;
    assign o_pop   = take && c_last;

    // Sequencer position and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_en) begin
                r_out_valid <= !i_empty;
            end
            if (take) begin
                if (c_last) begin
                    r_step <= '0;
                    r_dup  <= 1'b0;
                end else if (c_hold) begin
                    r_dup <= 1'b1;
                end else begin
                    r_step <= r_step + 4'd1;
                    r_dup  <= 1'b0;
                end
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind  <= c_kind;
            r_value <= c_value;
            r_last  <= c_last;
            r_echo  <= i_job.echo;
            r_naws  <= i_job.naws;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_kind;
    assign o_out.value     = r_value;
    assign o_out.last      = r_last;
    assign o_out.echo_mode = r_echo;
    assign o_out.naws_on   = r_naws;

endmodule

// ----- verif/tb_telnet_option_negotiator_unit.sv -----
`timescale 1ns / 100ps

module tb_telnet_option_negotiator_unit;
    import tono_pkg::*;

    localparam int MAX_REPLIES  = 16;
    localparam int PHASE_ITEMS  = 78;
    localparam int NUM_SETTINGS = 5;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Parser phases of the negotiator.
    typedef enum logic [2:0] {
        PH_DATA,
        PH_IAC,
        PH_OPT,
        PH_SUB,
        PH_SUB_IAC
    } t_rx_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
        logic [1:0] echo;
        logic       naws;
    } t_reply;

    typedef struct packed {
        logic       op;
        logic [7:0] rx;
        logic       typed;
        logic [1:0] kind;
        logic [7:0] value;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tono_in_if  in_if ();
    tono_out_if out_if ();

    telnet_option_negotiator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Directed bytes; a typed row carries its single reply as read off the spec.
    t_dir_row dir_tab [25] = '{
        '{1'b0, 8'h00,      1'b1, KIND_DATA, 8'h00},   // lowest data byte
        '{1'b0, 8'hFE,      1'b1, KIND_DATA, 8'hFE},   // highest plain data byte
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_IAC,      1'b1, KIND_DATA, B_IAC},   // doubled IAC is a literal
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_GA,       1'b1, KIND_GA,   8'h00},   // go-ahead event
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},
        '{1'b0, 8'hF1,      1'b0, KIND_DATA, 8'h00},   // any other command is dropped
        '{1'b1, 8'hFF,      1'b0, KIND_DATA, 8'h00},   // resize with reporting off
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_DO,       1'b0, KIND_DATA, 8'h00},
        '{1'b0, OPT_NAWS,   1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_WILL,     1'b0, KIND_DATA, 8'h00},
        '{1'b1, 8'h00,      1'b0, KIND_DATA, 8'h00},   // resize in the middle of a command
        '{1'b0, OPT_ECHO,   1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_SB,       1'b0, KIND_DATA, 8'h00},
        '{1'b0, OPT_TTYPE,  1'b0, KIND_DATA, 8'h00},
        '{1'b0, TTYPE_SEND, 1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},   // escaped 255 in the payload
        '{1'b0, B_IAC,      1'b0, KIND_DATA, 8'h00},
        '{1'b0, B_SE,       1'b0, KIND_DATA, 8'h00}
        , '{1'b0, 8'h7F,    1'b1, KIND_DATA, 8'h7F}
    };

    // Predictor state and its copy of the configuration.
    t_rx_phase   ph;
    logic [1:0]  m_verb;
    logic [1:0]  sub_cnt;
    logic [7:0]  sub_opt;
    logic [7:0]  sub_2nd;
    logic        m_naws;
    logic [1:0]  m_echo;
    logic [15:0] cfg_cols;
    logic [15:0] cfg_lines;
    logic        cfg_status;
    logic [63:0] cfg_name;
    logic [3:0]  cfg_len;

    t_reply burst[$];
    t_reply pending_replies[$];

    // Describes the transaction currently offered on the input channel.
    logic       cur_typed;
    logic [1:0] cur_kind;
    logic [7:0] cur_value;

    logic calm_tx;
    logic calm_rx;
    logic rx_hold_req;
    int   fail_cnt;
    int   items_sent;

    always #1 i_clk = ~i_clk;

    function automatic void emit(input logic [1:0] kind, input logic [7:0] value);
        t_reply r;
        r = '{kind: kind, value: value, last: 1'b0, echo: ECHO_UNKNOWN, naws: 1'b0};
        if (burst.size() < MAX_REPLIES)
            burst.push_back(r);
    endfunction

    // A size byte of 255 is sent twice.
    function automatic void emit_size_byte(input logic [7:0] b);
        if (b == B_IAC)
            emit(KIND_TX, B_IAC);
        emit(KIND_TX, b);
    endfunction

    function automatic void emit_window_size();
        logic [15:0] rows;
        if (!m_naws)
            return;
        rows = (cfg_lines >= 16'(cfg_status) + 16'd1) ?
               cfg_lines - 16'(cfg_status) - 16'd1 : 16'd0;
        emit(KIND_TX, B_IAC);
        emit(KIND_TX, B_SB);
        emit(KIND_TX, OPT_NAWS);
        emit_size_byte(cfg_cols[15:8]);
        emit_size_byte(cfg_cols[7:0]);
        emit_size_byte(rows[15:8]);
        emit_size_byte(rows[7:0]);
        emit(KIND_TX, B_IAC);
        emit(KIND_TX, B_SE);
    endfunction

    function automatic void sub_take(input logic [7:0] b);
        if (sub_cnt == 2'd0)
            sub_opt = b;
        else if (sub_cnt == 2'd1)
            sub_2nd = b;
        if (sub_cnt < 2'd2)
            sub_cnt = sub_cnt + 2'd1;
    endfunction

    // Answer one WILL, WONT, DO or DONT for an option.
    function automatic void answer_option(input logic [7:0] opt);
        logic [7:0] ans;
        if (m_verb == VERB_WILL || m_verb == VERB_WONT)
            ans = B_DONT;
        else if (m_verb == VERB_DONT)
            ans = B_WONT;
        else
            ans = (opt == OPT_ECHO || opt == OPT_TTYPE || opt == OPT_NAWS) ? B_WILL : B_WONT;
        if (opt == OPT_ECHO) begin
            if (m_verb == VERB_WILL)
                m_echo = ECHO_SERVER;
            if (m_verb == VERB_WONT)
                m_echo = ECHO_STOPPED;
        end else if (opt == OPT_NAWS) begin
            if (m_verb == VERB_WILL)
                ans = B_DO;
            m_naws = (m_verb == VERB_WILL || m_verb == VERB_DO);
        end
        emit(KIND_TX, B_IAC);
        emit(KIND_TX, ans);
        emit(KIND_TX, opt);
        if (opt == OPT_NAWS)
            emit_window_size();
    endfunction

    // A TERMINAL-TYPE SEND request is answered with the configured name.
    function automatic void emit_ttype_reply();
        int n;
        if (sub_cnt >= 2'd2 && sub_opt == OPT_TTYPE && sub_2nd == TTYPE_SEND) begin
            n = (cfg_len > TERM_MAX_CHARS_DEF) ? TERM_MAX_CHARS_DEF : int'(cfg_len);
            emit(KIND_TX, B_IAC);
            emit(KIND_TX, B_SB);
            emit(KIND_TX, OPT_TTYPE);
            emit(KIND_TX, TTYPE_IS);
            for (int i = 0; i < n; i++)
                emit(KIND_TX, cfg_name[8*i +: 8]);
            emit(KIND_TX, B_IAC);
            emit(KIND_TX, B_SE);
        end
    endfunction

    // Work out the replies that one input transaction causes.
    function automatic void parse_rx(input logic op, input logic [7:0] b);
        burst.delete();
        if (op) begin
            emit_window_size();
        end else begin
            case (ph)
                PH_DATA: begin
                    if (b == B_IAC)
                        ph = PH_IAC;
                    else
                        emit(KIND_DATA, b);
                end
                PH_IAC: begin
                    ph = PH_DATA;
                    if (b >= B_WILL && b <= B_DONT) begin
                        m_verb = 2'(b - B_WILL);
                        ph = PH_OPT;
                    end else if (b == B_SB) begin
                        sub_cnt = 2'd0;
                        sub_opt = 8'd0;
                        sub_2nd = 8'd0;
                        ph = PH_SUB;
                    end else if (b == B_GA) begin
                        emit(KIND_GA, 8'd0);
                    end else if (b == B_IAC) begin
                        emit(KIND_DATA, B_IAC);
                    end
                end
                PH_OPT: begin
                    ph = PH_DATA;
                    answer_option(b);
                end
                PH_SUB: begin
                    if (b == B_IAC)
                        ph = PH_SUB_IAC;
                    else
                        sub_take(b);
                end
                PH_SUB_IAC: begin
                    if (b == B_SE) begin
                        ph = PH_DATA;
                        emit_ttype_reply();
                    end else begin
                        ph = PH_SUB;
                        sub_take(B_IAC);
                        if (b != B_IAC)
                            sub_take(b);
                    end
                end
                default: ph = PH_DATA;
            endcase
        end
        foreach (burst[k]) begin
            burst[k].last = (k == burst.size() - 1);
            burst[k].echo = m_echo;
            burst[k].naws = m_naws;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Predict on every accepted input and check every accepted reply.
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                parse_rx(in_if.op, in_if.rx_byte);
                if (cur_typed) begin
                    burst.delete();
                    burst.push_back('{kind: cur_kind, value: cur_value, last: 1'b1,
                                      echo: m_echo, naws: m_naws});
                end
                foreach (burst[k])
                    pending_replies.push_back(burst[k]);
            end
            if (out_if.valid && out_if.ready) begin
                got = '{kind: out_if.kind, value: out_if.value, last: out_if.last,
                        echo: out_if.echo_mode, naws: out_if.naws_on};
                if (pending_replies.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("%0t: reply with none expected, actual %p", $time, got);
                end else begin
                    want = pending_replies.pop_front();
                    check_field("kind", 8'(want.kind), 8'(got.kind));
                    check_field("value", want.value, got.value);
                    check_field("last", 8'(want.last), 8'(got.last));
                    check_field("echo_mode", 8'(want.echo), 8'(got.echo));
                    check_field("naws_on", 8'(want.naws), 8'(got.naws));
                end
            end
        end
    end

    // Output ready: random stalls, calm stretches and one long hold-off.
    initial begin
        int hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                hold_left = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= calm_rx || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Offer one input transaction and wait until it is accepted.
    task automatic send_item(input logic op, input logic [7:0] b, input logic typed,
                             input logic [1:0] kind, input logic [7:0] value);
        @(negedge i_clk);
        while (!calm_tx && $urandom_range(0, 99) < 25) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.op      <= op;
        in_if.rx_byte <= b;
        cur_typed = typed;
        cur_kind  = kind;
        cur_value = value;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
    endtask

    task automatic send_resize();
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, KIND_DATA, 8'd0);
        items_sent++;
    endtask

    // A received byte, now and then preceded by a resize event.
    task automatic send_rx(input logic [7:0] b);
        if ($urandom_range(0, 99) < 4)
            send_resize();
        send_item(1'b0, b, 1'b0, KIND_DATA, 8'd0);
        items_sent++;
    endtask

    task automatic send_sub_byte(input logic [7:0] b);
        if (b == B_IAC)
            send_rx(B_IAC);
        send_rx(b);
    endtask

    task automatic send_subneg();
        int n;
        send_rx(B_IAC);
        send_rx(B_SB);
        case ($urandom_range(0, 5))
            0, 1: begin
                // Terminal type request, sometimes with trailing bytes.
                send_rx(OPT_TTYPE);
                send_rx(TTYPE_SEND);
                n = $urandom_range(0, 2);
                repeat (n) send_sub_byte(8'($urandom_range(0, 255)));
            end
            2: begin
                // Too short to be a request.
                n = $urandom_range(0, 1);
                repeat (n) send_rx(8'($urandom_range(0, 254)));
            end
            3: begin
                send_rx(B_IAC);
                send_rx(B_IAC);
                n = $urandom_range(0, 2);
                repeat (n) send_sub_byte(8'($urandom_range(0, 255)));
            end
            4: begin
                // IAC followed by a byte that is neither SE nor IAC.
                send_rx(B_IAC);
                send_rx(8'($urandom_range(0, 239)));
                n = $urandom_range(0, 1);
                repeat (n) send_sub_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                send_sub_byte($urandom_range(0, 1) ? OPT_TTYPE : 8'($urandom_range(0, 255)));
                n = $urandom_range(1, 4);
                repeat (n) send_sub_byte(8'($urandom_range(0, 255)));
            end
        endcase
        send_rx(B_IAC);
        send_rx(B_SE);
    endtask

    function automatic logic [7:0] pick_option();
        case ($urandom_range(0, 3))
            0:       return OPT_ECHO;
            1:       return OPT_TTYPE;
            2:       return OPT_NAWS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One well-formed sequence with random content, or a little noise.
    task automatic send_random_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            n = $urandom_range(1, 6);
            repeat (n) send_rx(8'($urandom_range(0, 254)));
        end else if (pick < 53) begin
            send_rx(B_IAC);
            send_rx(8'(B_WILL + $urandom_range(0, 3)));
            send_rx(pick_option());
        end else if (pick < 70) begin
            send_subneg();
        end else if (pick < 82) begin
            send_rx(B_IAC);
            case ($urandom_range(0, 2))
                0:       send_rx(B_GA);
                1:       send_rx(B_IAC);
                default: send_rx(8'($urandom_range(0, 239)));
            endcase
        end else if (pick < 88) begin
            send_resize();
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_rx(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_WINDOW_COLS:  cfg_cols   = data[15:0];
            CFG_WINDOW_LINES: cfg_lines  = data[15:0];
            CFG_STATUS_LINE:  cfg_status = data[0];
            CFG_TERM_NAME:    cfg_name   = data;
            CFG_TERM_LEN:     cfg_len    = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [63:0] cols, input logic [63:0] lines,
                                 input logic [63:0] status, input logic [63:0] name,
                                 input logic [63:0] len);
        write_reg(CFG_WINDOW_COLS, cols);
        write_reg(CFG_WINDOW_LINES, lines);
        write_reg(CFG_STATUS_LINE, status);
        write_reg(CFG_TERM_NAME, name);
        write_reg(CFG_TERM_LEN, len);
    endtask

    // Stop offering, wait for every reply, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        in_if.valid   <= 1'b0;
        in_if.op      <= 1'b0;
        in_if.rx_byte <= 8'd0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WINDOW_COLS;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        cur_typed   = 1'b0;
        cur_kind    = KIND_DATA;
        cur_value   = 8'd0;
        calm_tx     = 1'b0;
        calm_rx     = 1'b0;
        rx_hold_req = 1'b0;
        fail_cnt    = 0;
        items_sent  = 0;
        ph         = PH_DATA;
        m_verb     = VERB_WILL;
        sub_cnt    = 2'd0;
        sub_opt    = 8'd0;
        sub_2nd    = 8'd0;
        m_naws     = 1'b0;
        m_echo     = ECHO_UNKNOWN;
        cfg_cols   = COLS_RESET;
        cfg_lines  = LINES_RESET;
        cfg_status = 1'b0;
        cfg_name   = 64'd0;
        cfg_len    = 4'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset configuration.
        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].rx, dir_tab[i].typed,
                      dir_tab[i].kind, dir_tab[i].value);
        drain();

        // Random part, one configuration after another.
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            case (p)
                0: apply_setting(64'd0, 64'd0, 64'd1, rand64(), 64'd8);
                1: begin
                    apply_setting(64'hFFFF, 64'hFFFF, 64'd0, '1, 64'd15);
                    calm_tx = 1'b1;
                    calm_rx = 1'b1;
                end
                2: begin
                    apply_setting(64'h00FF, 64'h0100, 64'd0, rand64(), 64'd3);
                    write_reg(CFG_UNUSED, rand64());
                end
                3: begin
                    apply_setting(64'($urandom_range(0, 65535)), 64'd1, 64'd1, 64'd0, 64'd0);
                    calm_tx = 1'b1;
                    rx_hold_req = 1'b1;
                end
                default: apply_setting(rand64(), rand64(), rand64(), rand64(), rand64());
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                send_random_sequence();
            drain();
            calm_tx = 1'b0;
            calm_rx = 1'b0;
        end

        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d replies outstanding", $time, pending_replies.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
